@@ hw/rtl/mna_pkg.sv @@
`default_nettype none

package mna_pkg;

   // result field widths
   localparam int NUM_BITS  = 46;
   localparam int DEN_BITS  = 23;

   // bits of the multiplier operand taken per multiply step
   localparam int MUL_DIGIT = 8;

   // operation selector codes
   localparam logic [1:0] FUNC_CONV = 2'd0;
   localparam logic [1:0] FUNC_ADD  = 2'd1;
   localparam logic [1:0] FUNC_MUL  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   // multiply-accumulate operations: acc = a * b + c
   typedef enum logic [2:0] {
      MOP_CONV = 3'd0,  // wa * da + na  -> numerator
      MOP_DEN  = 3'd1,  // da * db       -> denominator
      MOP_NADB = 3'd2,  // na * db       -> temp
      MOP_DANB = 3'd3,  // da * nb + tmp -> temp
      MOP_SUM  = 3'd4,  // (wa + wb) * den + tmp -> numerator
      MOP_IA   = 3'd5,  // wa * da + na  -> temp
      MOP_IB   = 3'd6,  // wb * db + nb  -> temp2
      MOP_PROD = 3'd7   // temp * temp2  -> numerator
   } mop_type;

   typedef struct packed {
      logic    capture;
      logic    red_start;
      logic    gcd_step;
      logic    div_load;
      logic    div_step;
      logic    mul_load;
      logic    mul_step;
      logic    mul_write;
      logic    out_load;
      mop_type op;
   } cmd_type;

   typedef struct packed {
      logic       gcd_done;
      logic       div_error;
      logic       mul_zero;
      logic [1:0] func;
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/mna_if.sv @@
`default_nettype none

interface mna_req_if #(
   parameter int OPERAND_BITS = 12
) ();
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic signed [OPERAND_BITS-1:0] whole_a;
   logic signed [OPERAND_BITS-1:0] num_a;
   logic signed [OPERAND_BITS-1:0] den_a;
   logic signed [OPERAND_BITS-1:0] whole_b;
   logic signed [OPERAND_BITS-1:0] num_b;
   logic signed [OPERAND_BITS-1:0] den_b;

   modport source (
      output valid, func, whole_a, num_a, den_a, whole_b, num_b, den_b,
      input  ready
   );
   modport sink (
      input  valid, func, whole_a, num_a, den_a, whole_b, num_b, den_b,
      output ready
   );
endinterface

interface mna_rsp_if ();
   import mna_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [NUM_BITS-1:0] result_num;
   logic [DEN_BITS-1:0]        result_den;
   logic                       div_error;

   modport source (
      output valid, result_num, result_den, div_error,
      input  ready
   );
   modport sink (
      input  valid, result_num, result_den, div_error,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/mixed_number_add_multiply.sv @@
`default_nettype none

// Mixed number convert / add / multiply. Each request beat carries two mixed
// numbers (whole, numerator, denominator) and a selector; each one gives
// exactly one response beat with an improper fraction result_num/result_den:
// operand A alone, the sum or the product, or zeros for the unused selector.
// Each operand's fraction is first reduced by the gcd of |num| and |den|,
// with the sign moved onto the numerator; sum and product are not reduced
// again, and the numerator wraps at 46 bits, the denominator at 23. Zero over
// zero in either operand gives div_error with zeros. Items are worked one at
// a time: req ready is high only while the controller is idle, but a finished
// response sits in its own output register, so the next request is taken
// while it waits. The operands go through a binary gcd loop (one shift or
// subtract-and-shift per cycle, both operands in parallel), then through
// OPERAND_BITS restoring division steps, one per cycle, then through one
// shared multiply-accumulate unit taking 8 multiplier bits a cycle, up to 6
// digits; convert uses one multiply, add and multiply use four, the unused
// selector none. An operand that is zero over zero skips the division and
// the multiplies.

module mixed_number_add_multiply #(
   parameter int OPERAND_BITS = 12
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mna_req_if.sink    req_bus,
   mna_rsp_if.source  rsp_bus
);
   import mna_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: gcd, division, multiply ops and output handshake
   mna_ctrl #(.OPERAND_BITS(OPERAND_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: captured beat, two reduce lanes, multiplier, output register
   mna_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .func       (req_bus.func),
      .whole_a    (req_bus.whole_a),
      .num_a      (req_bus.num_a),
      .den_a      (req_bus.den_a),
      .whole_b    (req_bus.whole_b),
      .num_b      (req_bus.num_b),
      .den_b      (req_bus.den_b),
      .result_num (rsp_bus.result_num),
      .result_den (rsp_bus.result_den),
      .div_error  (rsp_bus.div_error)
   );

endmodule

`default_nettype wire

@@ hw/rtl/mna_reduce.sv @@
`default_nettype none

module mna_reduce #(
   parameter int OPERAND_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           gcd_step,
   input  wire logic                           div_load,
   input  wire logic                           div_step,
   input  wire logic signed [OPERAND_BITS-1:0] num_in,
   input  wire logic signed [OPERAND_BITS-1:0] den_in,
   output logic                                gcd_done,
   output logic                                zero_gcd,
   output logic signed [OPERAND_BITS:0]        num_out,
   output logic [OPERAND_BITS-1:0]             den_out
);
   import mna_pkg::*;

   localparam int N  = OPERAND_BITS;
   localparam int KW = $clog2(N);

   logic [N-1:0]  mag_num, mag_den;
   logic [N-1:0]  x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [KW-1:0] k_ff, k_in;
   logic          done_ff, done_in;
   logic          neg_ff;
   logic [N-1:0]  qn_ff, qd_ff;
   logic [N:0]    rn_ff, rd_ff;
   logic [2*N:0]  n_iter, d_iter;
   logic [N:0]    qn_ext;

   // one restoring division step: {remainder, quotient}
   function automatic logic [2*N:0] div_iter(input logic [N:0] rem,
                                             input logic [N-1:0] q,
                                             input logic [N-1:0] d);
      logic [N:0] sh;
      sh = {rem[N-1:0], q[N-1]};
      if (sh >= {1'b0, d}) begin
         return {sh - {1'b0, d}, q[N-2:0], 1'b1};
      end else begin
         return {sh, q[N-2:0], 1'b0};
      end
   endfunction

   assign mag_num = num_in[N-1] ? -num_in : num_in;
   assign mag_den = den_in[N-1] ? -den_in : den_in;

   // binary gcd, one shift or subtract-and-shift per step
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      done_in = done_ff;
      if (start) begin
         x_in    = mag_num;
         y_in    = mag_den;
         k_in    = '0;
         done_in = 1'b0;
      end else if (gcd_step && !done_ff) begin
         if (x_ff == '0 || y_ff == '0) begin
            g_in    = (x_ff | y_ff) << k_ff;
            done_in = 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in = (x_ff - y_ff) >> 1;
         end else begin
            y_in = (y_ff - x_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      k_ff <= k_in;
      g_ff <= g_in;
      if (start) begin
         neg_ff <= num_in[N-1] ^ den_in[N-1];
      end
   end

   assign n_iter = div_iter(rn_ff, qn_ff, g_ff);
   assign d_iter = div_iter(rd_ff, qd_ff, g_ff);

   // numerator and denominator divided by the gcd side by side
   always_ff @(posedge clock) begin
      if (div_load) begin
         qn_ff <= mag_num;
         rn_ff <= '0;
         qd_ff <= mag_den;
         rd_ff <= '0;
      end else if (div_step) begin
         rn_ff <= n_iter[2*N:N];
         qn_ff <= n_iter[N-1:0];
         rd_ff <= d_iter[2*N:N];
         qd_ff <= d_iter[N-1:0];
      end
   end

   assign qn_ext   = {1'b0, qn_ff};
   assign num_out  = neg_ff ? -qn_ext : qn_ext;
   assign den_out  = qd_ff;
   assign gcd_done = done_ff;
   assign zero_gcd = (g_ff == '0);

endmodule

`default_nettype wire

@@ hw/rtl/mna_mul.sv @@
`default_nettype none

module mna_mul (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic                          step,
   input  wire logic [mna_pkg::NUM_BITS-1:0]  a_in,
   input  wire logic [mna_pkg::NUM_BITS-1:0]  b_in,
   input  wire logic [mna_pkg::NUM_BITS-1:0]  c_in,
   output logic [mna_pkg::NUM_BITS-1:0]       acc,
   output logic                               b_zero
);
   import mna_pkg::*;

   logic [NUM_BITS-1:0] a_ff, b_ff, acc_ff, part;

   // multiplicand times the low digit of the shrinking multiplier
   assign part = a_ff * {{(NUM_BITS-MUL_DIGIT){1'b0}}, b_ff[MUL_DIGIT-1:0]};

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         acc_ff <= c_in;
      end else if (step) begin
         a_ff   <= a_ff << MUL_DIGIT;
         b_ff   <= b_ff >> MUL_DIGIT;
         acc_ff <= acc_ff + part;
      end
   end

   assign acc    = acc_ff;
   assign b_zero = (b_ff == '0);

endmodule

`default_nettype wire

@@ hw/rtl/mna_datapath.sv @@
`default_nettype none

module mna_datapath #(
   parameter int OPERAND_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mna_pkg::cmd_type               cmd,
   output mna_pkg::status_type                 status,
   input  wire logic [1:0]                     func,
   input  wire logic signed [OPERAND_BITS-1:0] whole_a,
   input  wire logic signed [OPERAND_BITS-1:0] num_a,
   input  wire logic signed [OPERAND_BITS-1:0] den_a,
   input  wire logic signed [OPERAND_BITS-1:0] whole_b,
   input  wire logic signed [OPERAND_BITS-1:0] num_b,
   input  wire logic signed [OPERAND_BITS-1:0] den_b,
   output logic signed [mna_pkg::NUM_BITS-1:0] result_num,
   output logic [mna_pkg::DEN_BITS-1:0]        result_den,
   output logic                                div_error
);
   import mna_pkg::*;

   localparam int N = OPERAND_BITS;

   logic [1:0]          func_ff;
   logic signed [N-1:0] wa_ff, wb_ff, na_raw_ff, da_raw_ff, nb_raw_ff, db_raw_ff;
   logic signed [N:0]   na, nb;
   logic [N-1:0]        da, db;
   logic                done_a, done_b, zero_a, zero_b;
   logic [NUM_BITS-1:0] wa_x, wb_x, na_x, nb_x, da_x, db_x, sum_w;
   logic [NUM_BITS-1:0] den_ff, tmp_ff, tmp2_ff, num_ff;
   logic [NUM_BITS-1:0] mul_a, mul_b, mul_c, mul_acc;
   logic                mul_zero;
   logic signed [NUM_BITS-1:0] out_num_ff;
   logic [DEN_BITS-1:0] out_den_ff;
   logic                out_err_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= func;
         wa_ff     <= whole_a;
         na_raw_ff <= num_a;
         da_raw_ff <= den_a;
         wb_ff     <= whole_b;
         nb_raw_ff <= num_b;
         db_raw_ff <= den_b;
      end
   end

   mna_reduce #(.OPERAND_BITS(N)) u_red_a (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.red_start),
      .gcd_step (cmd.gcd_step),
      .div_load (cmd.div_load),
      .div_step (cmd.div_step),
      .num_in   (na_raw_ff),
      .den_in   (da_raw_ff),
      .gcd_done (done_a),
      .zero_gcd (zero_a),
      .num_out  (na),
      .den_out  (da)
   );

   mna_reduce #(.OPERAND_BITS(N)) u_red_b (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.red_start),
      .gcd_step (cmd.gcd_step),
      .div_load (cmd.div_load),
      .div_step (cmd.div_step),
      .num_in   (nb_raw_ff),
      .den_in   (db_raw_ff),
      .gcd_done (done_b),
      .zero_gcd (zero_b),
      .num_out  (nb),
      .den_out  (db)
   );

   // everything below wraps modulo two to the result width
   assign wa_x  = NUM_BITS'(wa_ff);
   assign wb_x  = NUM_BITS'(wb_ff);
   assign na_x  = NUM_BITS'(na);
   assign nb_x  = NUM_BITS'(nb);
   assign da_x  = NUM_BITS'(da);
   assign db_x  = NUM_BITS'(db);
   assign sum_w = wa_x + wb_x;

   always_comb begin
      case (cmd.op)
         MOP_CONV: begin mul_a = wa_x;   mul_b = da_x;    mul_c = na_x;   end
         MOP_DEN:  begin mul_a = da_x;   mul_b = db_x;    mul_c = '0;     end
         MOP_NADB: begin mul_a = na_x;   mul_b = db_x;    mul_c = '0;     end
         MOP_DANB: begin mul_a = da_x;   mul_b = nb_x;    mul_c = tmp_ff; end
         MOP_SUM:  begin mul_a = sum_w;  mul_b = den_ff;  mul_c = tmp_ff; end
         MOP_IA:   begin mul_a = wa_x;   mul_b = da_x;    mul_c = na_x;   end
         MOP_IB:   begin mul_a = wb_x;   mul_b = db_x;    mul_c = nb_x;   end
         MOP_PROD: begin mul_a = tmp_ff; mul_b = tmp2_ff; mul_c = '0;     end
         default:  begin mul_a = '0;     mul_b = '0;      mul_c = '0;     end
      endcase
   end

   mna_mul u_mul (
      .clock  (clock),
      .load   (cmd.mul_load),
      .step   (cmd.mul_step),
      .a_in   (mul_a),
      .b_in   (mul_b),
      .c_in   (mul_c),
      .acc    (mul_acc),
      .b_zero (mul_zero)
   );

   always_ff @(posedge clock) begin
      if (cmd.mul_write) begin
         case (cmd.op)
            MOP_CONV, MOP_SUM, MOP_PROD: num_ff  <= mul_acc;
            MOP_DEN:                     den_ff  <= mul_acc;
            MOP_NADB, MOP_DANB, MOP_IA:  tmp_ff  <= mul_acc;
            MOP_IB:                      tmp2_ff <= mul_acc;
            default:                     num_ff  <= mul_acc;
         endcase
      end
   end

   // output register, loaded when the previous beat is gone
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (zero_a || zero_b) begin
            out_num_ff <= '0;
            out_den_ff <= '0;
            out_err_ff <= 1'b1;
         end else begin
            out_err_ff <= 1'b0;
            case (func_ff)
               FUNC_CONV: begin
                  out_num_ff <= num_ff;
                  out_den_ff <= DEN_BITS'(da);
               end
               FUNC_ADD, FUNC_MUL: begin
                  out_num_ff <= num_ff;
                  out_den_ff <= den_ff[DEN_BITS-1:0];
               end
               default: begin
                  out_num_ff <= '0;
                  out_den_ff <= '0;
               end
            endcase
         end
      end
   end

   assign result_num       = out_num_ff;
   assign result_den       = out_den_ff;
   assign div_error        = out_err_ff;

   assign status.gcd_done  = done_a & done_b;
   assign status.div_error = zero_a | zero_b;
   assign status.mul_zero  = mul_zero;
   assign status.func      = func_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mna_ctrl.sv @@
`default_nettype none

module mna_ctrl #(
   parameter int OPERAND_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire mna_pkg::status_type status,
   output mna_pkg::cmd_type         cmd
);
   import mna_pkg::*;

   localparam int         N           = OPERAND_BITS;
   localparam int         CW          = $clog2(N);
   localparam logic [1:0] LAST_OP_IDX = 2'd3;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_START  = 8'b0000_0010,
      S_GCD    = 8'b0000_0100,
      S_DIVLD  = 8'b0000_1000,
      S_DIV    = 8'b0001_0000,
      S_MULLD  = 8'b0010_0000,
      S_MULRUN = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    idx_ff, idx_in;
   logic          valid_ff, valid_in;
   mop_type       cur_op;
   logic          last_op;

   function automatic mop_type op_of(input logic [1:0] f, input logic [1:0] idx);
      mop_type op;
      case (f)
         FUNC_CONV: op = MOP_CONV;
         FUNC_ADD: begin
            case (idx)
               2'd0:    op = MOP_DEN;
               2'd1:    op = MOP_NADB;
               2'd2:    op = MOP_DANB;
               default: op = MOP_SUM;
            endcase
         end
         default: begin
            case (idx)
               2'd0:    op = MOP_DEN;
               2'd1:    op = MOP_IA;
               2'd2:    op = MOP_IB;
               default: op = MOP_PROD;
            endcase
         end
      endcase
      return op;
   endfunction

   assign cur_op  = op_of(status.func, idx_ff);
   assign last_op = (status.func == FUNC_CONV) || (idx_ff == LAST_OP_IDX);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.op    = cur_op;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            cmd.red_start = 1'b1;
            state_in      = S_GCD;
         end
         S_GCD: begin
            cmd.gcd_step = 1'b1;
            if (status.gcd_done) begin
               state_in = status.div_error ? S_FINISH : S_DIVLD;
            end
         end
         S_DIVLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(N - 1)) begin
               idx_in   = '0;
               state_in = (status.func == FUNC_NONE) ? S_FINISH : S_MULLD;
            end
         end
         S_MULLD: begin
            cmd.mul_load = 1'b1;
            state_in     = S_MULRUN;
         end
         S_MULRUN: begin
            if (status.mul_zero) begin
               cmd.mul_write = 1'b1;
               idx_in        = idx_ff + 1'b1;
               state_in      = last_op ? S_FINISH : S_MULLD;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (!valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

@@ verif/mixed_number_add_multiply_tb.sv @@
module mixed_number_add_multiply_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mna_pkg::*;

   localparam int OPERAND_BITS = 12;

   // wait after the last expected beat, so that a stray extra beat can show up
   localparam int DRAIN_CYCLES = 200;
   // long receiver hold-off that lets the block fill up and stall its input
   localparam int RSP_HOLD_CYCLES = 300;

   // field extremes at the operand width
   localparam logic signed [OPERAND_BITS-1:0] FIELD_MIN = {1'b1, {(OPERAND_BITS-1){1'b0}}};
   localparam logic signed [OPERAND_BITS-1:0] FIELD_MAX = {1'b0, {(OPERAND_BITS-1){1'b1}}};

   // one request beat: selector plus two mixed numbers
   typedef struct packed {
      logic [1:0]                     func;
      logic signed [OPERAND_BITS-1:0] whole_a;
      logic signed [OPERAND_BITS-1:0] num_a;
      logic signed [OPERAND_BITS-1:0] den_a;
      logic signed [OPERAND_BITS-1:0] whole_b;
      logic signed [OPERAND_BITS-1:0] num_b;
      logic signed [OPERAND_BITS-1:0] den_b;
   } mixed_pair_type;

   // one response beat: improper fraction and error flag
   typedef struct packed {
      logic [NUM_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
      logic                err;
   } fraction_result_type;

   logic clock = 1'b0;
   logic reset;

   mna_req_if #(.OPERAND_BITS(OPERAND_BITS)) req_bus ();
   mna_rsp_if rsp_bus ();

   mixed_number_add_multiply #(
      .OPERAND_BITS(OPERAND_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // fractions still owed by the block, oldest first
   fraction_result_type expected_fractions[$];
   int                  failures = 0;

   // when set, neither side idles
   bit no_idle = 1'b0;
   // asks the receiver process for one long hold-off
   bit hold_request = 1'b0;
   int hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // plain euclid with modulo on magnitudes
   function automatic longint unsigned euclid_gcd(input longint unsigned x,
                                                  input longint unsigned y);
      while (x != 0 && y != 0) begin
         if (x >= y)
            x = x % y;
         else
            y = y % x;
      end
      return x + y;
   endfunction

   // reduce n/d by the gcd and put the sign on the numerator;
   // returns 0 on zero over zero
   function automatic bit reduce_fraction(input longint n, input longint d,
                                          output longint rn, output longint rd);
      longint unsigned g;
      g = euclid_gcd(n < 0 ? -n : n, d < 0 ? -d : d);
      rn = 0;
      rd = 0;
      if (g == 0)
         return 1'b0;
      rn = n / $signed(g);
      rd = d / $signed(g);
      if (rd < 0) begin
         rn = -rn;
         rd = -rd;
      end
      return 1'b1;
   endfunction

   // expected response for one request; 64-bit math wraps, then cut to the field widths
   function automatic fraction_result_type predict_fraction(input mixed_pair_type p);
      longint              wa, wb, na, da, nb, db, rnum, rden;
      bit                  ok_a, ok_b;
      fraction_result_type r;
      wa = p.whole_a;
      wb = p.whole_b;
      ok_a = reduce_fraction(p.num_a, p.den_a, na, da);
      ok_b = reduce_fraction(p.num_b, p.den_b, nb, db);
      rnum = 0;
      rden = 0;
      // zero over zero in either operand wins over any selector
      if (!(ok_a && ok_b)) begin
         r.num = '0;
         r.den = '0;
         r.err = 1'b1;
         return r;
      end
      case (p.func)
         FUNC_CONV: begin
            rden = da;
            rnum = wa * da + na;
         end
         FUNC_ADD: begin
            rden = da * db;
            rnum = (wa + wb) * rden + na * db + da * nb;
         end
         FUNC_MUL: begin
            rden = da * db;
            rnum = (wa * da + na) * (wb * db + nb);
         end
         default: ;  // unused selector answers with zeros
      endcase
      r.num = rnum[NUM_BITS-1:0];
      r.den = rden[DEN_BITS-1:0];
      r.err = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic mixed_pair_type make_pair(input logic [1:0] func,
                                                input logic signed [OPERAND_BITS-1:0] wa,
                                                input logic signed [OPERAND_BITS-1:0] na,
                                                input logic signed [OPERAND_BITS-1:0] da,
                                                input logic signed [OPERAND_BITS-1:0] wb,
                                                input logic signed [OPERAND_BITS-1:0] nb,
                                                input logic signed [OPERAND_BITS-1:0] db);
      mixed_pair_type p;
      p.func    = func;
      p.whole_a = wa;
      p.num_a   = na;
      p.den_a   = da;
      p.whole_b = wb;
      p.num_b   = nb;
      p.den_b   = db;
      return p;
   endfunction

   // mostly full range, with a share of small values, zeros and extremes so that
   // common factors, zero numerators and zero denominators turn up often
   function automatic logic signed [OPERAND_BITS-1:0] random_field();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return OPERAND_BITS'($urandom);
      else if (pick < 78)
         return OPERAND_BITS'(int'($urandom_range(0, 24)) - 12);
      else if (pick < 88)
         return '0;
      case ($urandom_range(0, 3))
         0:       return FIELD_MIN;
         1:       return FIELD_MAX;
         2:       return '1;
         default: return OPERAND_BITS'(1);
      endcase
   endfunction

   function automatic mixed_pair_type random_pair();
      logic [1:0] func;
      // unused selector now and then, the three real operations evenly otherwise
      if ($urandom_range(0, 99) < 6)
         func = FUNC_NONE;
      else
         case ($urandom_range(0, 2))
            0:       func = FUNC_CONV;
            1:       func = FUNC_ADD;
            default: func = FUNC_MUL;
         endcase
      return make_pair(func, random_field(), random_field(), random_field(),
                       random_field(), random_field(), random_field());
   endfunction

   // offer one beat, maybe after a short gap, and wait for it to be taken;
   // valid stays high on return so that a following beat goes out back to back
   task automatic send_pair(input mixed_pair_type p);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < 13) begin
         gap = $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= p.func;
      req_bus.whole_a <= p.whole_a;
      req_bus.num_a   <= p.num_a;
      req_bus.den_a   <= p.den_a;
      req_bus.whole_b <= p.whole_b;
      req_bus.num_b   <= p.num_b;
      req_bus.den_b   <= p.den_b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      expected_fractions.push_back(predict_fraction(p));
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   task automatic run_directed_cases();
      // plain operations, reduction, sign moved off a negative denominator
      send_pair(make_pair(FUNC_CONV, 1, 1, 2, 0, 1, 1));
      send_pair(make_pair(FUNC_CONV, 2, 6, 8, 0, 1, 1));
      send_pair(make_pair(FUNC_CONV, 0, 3, -6, 0, 1, 1));
      send_pair(make_pair(FUNC_CONV, -1, -1, -1, 0, 1, 1));
      send_pair(make_pair(FUNC_ADD, 1, 1, 2, 2, 1, 3));
      send_pair(make_pair(FUNC_ADD, -3, -4, 6, 5, 7, -14));
      send_pair(make_pair(FUNC_MUL, 1, 1, 2, 2, 1, 3));
      send_pair(make_pair(FUNC_MUL, -2, 9, -12, 3, -10, 4));
      // field extremes
      send_pair(make_pair(FUNC_ADD, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                          FIELD_MAX, FIELD_MAX, FIELD_MAX));
      send_pair(make_pair(FUNC_MUL, FIELD_MIN, FIELD_MIN, FIELD_MAX,
                          FIELD_MIN, FIELD_MAX, FIELD_MIN));
      send_pair(make_pair(FUNC_MUL, FIELD_MAX, FIELD_MAX, FIELD_MIN,
                          FIELD_MAX, FIELD_MAX, FIELD_MIN));
      send_pair(make_pair(FUNC_CONV, FIELD_MIN, FIELD_MIN, FIELD_MIN, 0, 1, 1));
      send_pair(make_pair(FUNC_ADD, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                          FIELD_MIN, FIELD_MIN, FIELD_MIN));
      send_pair(make_pair(FUNC_MUL, 0, FIELD_MAX, 1, 0, FIELD_MIN, 1));
      // zero over zero in A, in B, in both, with convert, add and multiply
      send_pair(make_pair(FUNC_CONV, 5, 0, 0, 1, 1, 1));
      send_pair(make_pair(FUNC_CONV, 5, 1, 2, 3, 0, 0));
      send_pair(make_pair(FUNC_ADD, 7, 0, 0, 2, 3, 4));
      send_pair(make_pair(FUNC_MUL, FIELD_MIN, 0, 0, FIELD_MAX, 0, 0));
      // zero denominator alone: numerator collapses to plus or minus one
      send_pair(make_pair(FUNC_CONV, 3, 5, 0, 0, 1, 1));
      send_pair(make_pair(FUNC_ADD, 1, -7, 0, 2, 1, 3));
      send_pair(make_pair(FUNC_MUL, 2, 4, 0, -1, -9, 0));
      // zero numerator over a nonzero denominator reduces to 0/1
      send_pair(make_pair(FUNC_ADD, 0, 0, 5, 0, 0, -7));
      // unused selector, with and without the error
      send_pair(make_pair(FUNC_NONE, 1, 2, 3, 4, 5, 6));
      send_pair(make_pair(FUNC_NONE, 1, 0, 0, 1, 1, 1));
   endtask

   task automatic run_random_operands();
      repeat (620)
         send_pair(random_pair());
   endtask

   // long stretch with neither side idling
   task automatic run_back_to_back();
      no_idle = 1'b1;
      repeat (150)
         send_pair(random_pair());
      no_idle = 1'b0;
   endtask

   // receiver holds off while beats keep coming, so the output register and the
   // controller both fill and req ready drops
   task automatic run_output_backpressure();
      hold_request = 1'b1;
      repeat (12)
         send_pair(random_pair());
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random stalls, plus the one long hold-off counted here
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = RSP_HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 13);
      end
   end

   // ---------------------------------------------------------------------------
   // checker: every accepted response beat against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_fractions.size() == 0) begin
            $error("response beat with nothing expected: num %0d den %0d div_error %0b",
                   rsp_bus.result_num, rsp_bus.result_den, rsp_bus.div_error);
            failures++;
         end else begin
            want = expected_fractions.pop_front();
            if (rsp_bus.result_num !== want.num) begin
               $error("result_num expected %0d actual %0d",
                      $signed(want.num), rsp_bus.result_num);
               failures++;
            end
            if (rsp_bus.result_den !== want.den) begin
               $error("result_den expected %0d actual %0d", want.den, rsp_bus.result_den);
               failures++;
            end
            if (rsp_bus.div_error !== want.err) begin
               $error("div_error expected %0b actual %0b", want.err, rsp_bus.div_error);
               failures++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_CONV;
      req_bus.whole_a = '0;
      req_bus.num_a   = '0;
      req_bus.den_a   = '0;
      req_bus.whole_b = '0;
      req_bus.num_b   = '0;
      req_bus.den_b   = '0;
      rsp_bus.ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed_cases();
      run_random_operands();
      run_back_to_back();
      run_output_backpressure();
      req_bus.valid <= 1'b0;

      // drain, then give a stray extra beat time to show up
      while (expected_fractions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
